@@ hw/rtl/jpt_pkg.sv @@
`timescale 1ns / 1ps

package jpt_pkg;

    localparam int OP_W    = 2;
    localparam int CFG_W   = 7;
    localparam int INDEX_W = 6;
    localparam int TICKS_W = 24;
    localparam int TICK_W  = 32;
    localparam int IEND_W  = 33;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;
    localparam logic [OP_W-1:0] OP_SET   = 2'd3;

    // load enables of the two divider stages, one per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage

@@ hw/rtl/jpt_ram.sv @@
`timescale 1ns / 1ps

module jpt_ram #(
    parameter int WIDTH = 264,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a read of the address being written returns the new data
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/jpt_div6.sv @@
`timescale 1ns / 1ps

// floor(x / 6) in two register stages: floor(floor(x / 2) / 3), with the
// division by 3 done by folding 32- and 16-bit digits (2^32 and 2^16 are
// both 1 mod 3) and a small reciprocal multiply on the final 17-bit digit sum.
module jpt_div6 #(
    parameter int VALUE_BITS = 48
) (
    input  logic                         clk,
    input  jpt_pkg::stage_en_t           en,
    input  logic signed [VALUE_BITS-1:0] din,
    output logic signed [VALUE_BITS-1:0] quot
);

    localparam int VB = VALUE_BITS;
    localparam logic [VB:0]   BIAS    = (VB + 1)'(3) << (VB - 2);
    localparam logic [VB-1:0] QOFF    = VB'(1) << (VB - 2);
    localparam logic [31:0]   M32     = 32'h5555_5555;
    localparam logic [15:0]   M16     = 16'h5555;
    localparam logic [16:0]   RECIP3  = 17'h0AAAB;

    logic signed [VB-1:0] half;
    logic [VB:0]          biased;
    logic [63:0]          u64;
    logic [63:0]          prod_next;
    logic [32:0]          sum_next;
    logic [63:0]          prod_reg;
    logic [32:0]          sum_reg;
    logic [31:0]          mid_prod;
    logic [63:0]          part_next;
    logic [16:0]          digit_next;
    logic [63:0]          part_reg;
    logic [16:0]          digit_reg;
    logic [16:0]          last_sum;
    logic [33:0]          last_prod;
    logic [63:0]          total;

    assign half      = din >>> 1;
    assign biased    = {half[VB-1], half} + BIAS;
    assign u64       = 64'(biased[VB-1:0]);
    assign prod_next = u64[63:32] * M32;
    assign sum_next  = {1'b0, u64[63:32]} + {1'b0, u64[31:0]};

    assign mid_prod   = sum_reg[31:16] * M16;
    assign part_next  = prod_reg + (sum_reg[32] ? 64'(M32) : 64'd0) + 64'(mid_prod);
    assign digit_next = 17'(sum_reg[32]) + 17'(sum_reg[31:16]) + 17'(sum_reg[15:0]);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
        if (en.s2)
        begin
            part_reg  <= part_next;
            digit_reg <= digit_next;
        end
    end

    assign last_sum  = 17'(digit_reg[16]) + 17'(digit_reg[15:0]);
    assign last_prod = last_sum * RECIP3;
    assign total     = part_reg + (digit_reg[16] ? 64'(M16) : 64'd0)
                       + 64'(last_prod[32:17]);
    assign quot      = $signed(total[VB-1:0] - QOFF);

endmodule

@@ hw/rtl/jerk_profile_trajectory_generator.sv @@
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                                tuser
// s_*       in   seg_index, seg_ticks, seg_jerk, seg_acc,          operation
//                seg_vel, seg_pos, position, zero pad
// m_*       out  pos_out, vel_out, acc_out, jerk_out, zero pad     done_res, accepted
// cfg_*     in   cfg_wdata = segment_count                         -
//
// One item per cycle while the output is not stalled; input is registered in data0,
// then data1 and data2, and its result in the output register. The rate is set by
// the per-tick segment state update (counters, pointer, saturating integrators).
// Reset is asynchronous, active low; the segment table is not cleared.
// Each stage holds while the next one is full, so a stalled output does not
// block input transfers until the pipeline fills.
module jerk_profile_trajectory_generator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int VALUE_BITS   = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jpt_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // seg_index, seg_ticks, seg_jerk, seg_acc, seg_vel, seg_pos, position
    input  logic [((30+5*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic [jpt_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_out, vel_out, acc_out, jerk_out
    output logic [((4*VALUE_BITS+7)/8)*8-1:0] m_tdata,
    // done_res, accepted
    output logic [1:0]                        m_tuser
);

    localparam int VB     = VALUE_BITS;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CW_RAW = $clog2(MAX_SEGMENTS + 2) + 1;
    localparam int CW     = (CW_RAW > 7) ? CW_RAW : 7;
    localparam int IN_RAW = 30 + 5 * VB;
    localparam int OUT_W  = ((4 * VB + 7) / 8) * 8;
    localparam int E_W    = jpt_pkg::TICKS_W + 5 * VB;
    localparam int F_JERK = 30;
    localparam int F_ACC  = 30 + VB;
    localparam int F_VEL  = 30 + 2 * VB;
    localparam int F_POS  = 30 + 3 * VB;
    localparam int F_POSN = 30 + 4 * VB;
    localparam int E_JERK = jpt_pkg::TICKS_W;
    localparam int E_J6   = jpt_pkg::TICKS_W + VB;
    localparam int E_ACC  = jpt_pkg::TICKS_W + 2 * VB;
    localparam int E_VEL  = jpt_pkg::TICKS_W + 3 * VB;
    localparam int E_POS  = jpt_pkg::TICKS_W + 4 * VB;

    function automatic logic signed [VB-1:0] sat_add(input logic signed [VB-1:0] a,
                                                      input logic signed [VB-1:0] b);
        logic [VB:0] s;
        s = {a[VB-1], a} + {b[VB-1], b};
        if (s[VB] != s[VB-1])
        begin
            sat_add = s[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
        end
        else
        begin
            sat_add = s[VB-1:0];
        end
    endfunction

    // pipeline
    logic                       v0_reg, v1_reg, v2_reg, m_tvalid_reg;
    logic [jpt_pkg::OP_W-1:0]   op0_reg, op1_reg, op2_reg;
    logic [IN_RAW-1:0]          data0_reg, data1_reg, data2_reg;
    logic                       out_free, r2_ready, r1_ready;
    logic                       r0_move, r1_move, proc;
    jpt_pkg::stage_en_t         div_en;
    logic signed [VB-1:0]       jerk_div6;

    // state
    logic [jpt_pkg::CFG_W-1:0]  cnt_reg;
    logic signed [VB-1:0]       offset_reg, offset_next;
    logic [jpt_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [jpt_pkg::IEND_W-1:0] iend_reg, iend_next;
    logic [IDX_W-1:0]           sp_reg, sp_next;
    logic                       first_reg, first_next;
    logic                       idle_reg, idle_next;
    logic signed [VB-1:0]       pos_reg, pos_next, vel_reg, vel_next;
    logic signed [VB-1:0]       acc_reg, acc_next, jerk_reg, jerk_next;
    logic                       acc_flag;
    logic [OUT_W-1:0]           m_tdata_reg;
    logic [1:0]                 m_tuser_reg;

    // table
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr, rd_addr_b;
    logic [E_W-1:0]             ram_wdata, ent_a, ent_b;
    logic [CW-1:0]              widx_wide;

    // datapath
    logic [CW-1:0]              cnt_wide, cnt_eff, sp_wide;
    logic                       run, in_window;
    logic [jpt_pkg::TICK_W-1:0] tick_inc;
    logic [jpt_pkg::IEND_W:0]   iend_sum_a, iend_sum_b;
    logic [jpt_pkg::IEND_W-1:0] iend_load_a, iend_load_b;
    logic signed [VB-1:0]       a_jerk, a_j6, int_acc, int_vel, int_pos;
    logic signed [VB-1:0]       posn2;

    assign out_free = !m_tvalid_reg || m_tready;
    assign r2_ready = !v2_reg || out_free;
    assign r1_ready = !v1_reg || r2_ready;
    assign s_tready = !v0_reg || r1_ready;
    assign r0_move  = v0_reg && r1_ready;
    assign r1_move  = v1_reg && r2_ready;
    assign proc     = v2_reg && out_free;

    assign div_en.s1 = r0_move;
    assign div_en.s2 = r1_move;

    jpt_div6 #(
        .VALUE_BITS(VB)
    ) u_div6 (
        .clk  (clk),
        .en   (div_en),
        .din  ($signed(data0_reg[F_JERK +: VB])),
        .quot (jerk_div6)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v0_reg <= s_tvalid;
            end
            if (r1_ready)
            begin
                v1_reg <= v0_reg;
            end
            if (r2_ready)
            begin
                v2_reg <= v1_reg;
            end
            if (out_free)
            begin
                m_tvalid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op0_reg   <= s_tuser;
            data0_reg <= s_tdata[IN_RAW-1:0];
        end
        if (r0_move)
        begin
            op1_reg   <= op0_reg;
            data1_reg <= data0_reg;
        end
        if (r1_move)
        begin
            op2_reg   <= op1_reg;
            data2_reg <= data1_reg;
        end
        if (proc)
        begin
            m_tdata_reg <= OUT_W'({jerk_next, acc_next, vel_next, pos_next});
            m_tuser_reg <= {acc_flag, idle_next};
        end
    end

    // segment table: port A reads the current segment, port B the one after it
    assign widx_wide = CW'(data2_reg[jpt_pkg::INDEX_W-1:0]);
    assign ram_waddr = widx_wide[IDX_W-1:0];
    assign ram_we    = proc && (op2_reg == jpt_pkg::OP_WRITE)
                       && (widx_wide < CW'(MAX_SEGMENTS));
    assign ram_wdata = {data2_reg[F_POS +: VB], data2_reg[F_VEL +: VB],
                        data2_reg[F_ACC +: VB], jerk_div6, data2_reg[F_JERK +: VB],
                        data2_reg[29:6]};
    assign rd_addr_b = sp_next + IDX_W'(1);

    jpt_ram #(
        .WIDTH(E_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (sp_next),
        .rdata (ent_a)
    );

    jpt_ram #(
        .WIDTH(E_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_b),
        .rdata (ent_b)
    );

    assign cnt_wide  = CW'(cnt_reg);
    assign cnt_eff   = (cnt_wide > CW'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS) : cnt_wide;
    assign sp_wide   = CW'(sp_reg);
    assign run       = !idle_reg && (cnt_eff != '0) && (sp_wide < cnt_eff);
    assign in_window = !iend_reg[jpt_pkg::IEND_W-1] && ({1'b0, tick_reg} <= iend_reg);
    assign tick_inc  = (&tick_reg) ? tick_reg : tick_reg + 1'b1;

    // iend never drops below -1, so the sum is negative only at -1
    assign iend_sum_a  = {iend_reg[jpt_pkg::IEND_W-1], iend_reg}
                         + (jpt_pkg::IEND_W+1)'(ent_a[jpt_pkg::TICKS_W-1:0]);
    assign iend_sum_b  = {iend_reg[jpt_pkg::IEND_W-1], iend_reg}
                         + (jpt_pkg::IEND_W+1)'(ent_b[jpt_pkg::TICKS_W-1:0]);
    assign iend_load_a = (!iend_sum_a[jpt_pkg::IEND_W] && iend_sum_a[jpt_pkg::IEND_W-1])
                         ? {1'b0, {jpt_pkg::TICK_W{1'b1}}} : iend_sum_a[jpt_pkg::IEND_W-1:0];
    assign iend_load_b = (!iend_sum_b[jpt_pkg::IEND_W] && iend_sum_b[jpt_pkg::IEND_W-1])
                         ? {1'b0, {jpt_pkg::TICK_W{1'b1}}} : iend_sum_b[jpt_pkg::IEND_W-1:0];

    assign a_jerk  = $signed(ent_a[E_JERK +: VB]);
    assign a_j6    = $signed(ent_a[E_J6 +: VB]);
    assign int_acc = sat_add(acc_reg, a_jerk);
    assign int_vel = sat_add(sat_add(vel_reg, acc_reg), a_jerk >>> 1);
    assign int_pos = sat_add(sat_add(sat_add(pos_reg, vel_reg), acc_reg >>> 1), a_j6);
    assign posn2   = $signed(data2_reg[F_POSN +: VB]);

    always_comb
    begin
        offset_next = offset_reg;
        tick_next   = tick_reg;
        iend_next   = iend_reg;
        sp_next     = sp_reg;
        first_next  = first_reg;
        idle_next   = idle_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        acc_next    = acc_reg;
        jerk_next   = jerk_reg;
        acc_flag    = 1'b0;
        if (proc)
        begin
            unique case (op2_reg)
                jpt_pkg::OP_TICK:
                begin
                    if (run)
                    begin
                        if (in_window)
                        begin
                            jerk_next = a_jerk;
                            acc_next  = int_acc;
                            vel_next  = int_vel;
                            pos_next  = int_pos;
                        end
                        else if (first_reg)
                        begin
                            first_next = 1'b0;
                            sp_next    = '0;
                            iend_next  = iend_load_a;
                            jerk_next  = a_jerk;
                            acc_next   = $signed(ent_a[E_ACC +: VB]);
                            vel_next   = $signed(ent_a[E_VEL +: VB]);
                            pos_next   = sat_add($signed(ent_a[E_POS +: VB]), offset_reg);
                            if (cnt_eff <= CW'(1))
                            begin
                                idle_next = 1'b1;
                            end
                        end
                        else if (sp_wide + CW'(1) >= cnt_eff)
                        begin
                            idle_next = 1'b1;
                        end
                        else
                        begin
                            sp_next   = sp_reg + IDX_W'(1);
                            iend_next = iend_load_b;
                            jerk_next = $signed(ent_b[E_JERK +: VB]);
                            acc_next  = $signed(ent_b[E_ACC +: VB]);
                            vel_next  = $signed(ent_b[E_VEL +: VB]);
                            pos_next  = sat_add($signed(ent_b[E_POS +: VB]), offset_reg);
                            if (sp_wide + CW'(2) >= cnt_eff)
                            begin
                                idle_next = 1'b1;
                            end
                        end
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next  = jpt_pkg::TICK_W'(1);
                        iend_next  = '1;
                        sp_next    = '0;
                        first_next = 1'b1;
                    end
                end
                jpt_pkg::OP_WRITE:
                begin
                end
                jpt_pkg::OP_START:
                begin
                    if (idle_reg && (cnt_eff != '0))
                    begin
                        offset_next = posn2;
                        tick_next   = '0;
                        iend_next   = '1;
                        sp_next     = '0;
                        first_next  = 1'b1;
                        idle_next   = 1'b0;
                        acc_flag    = 1'b1;
                    end
                end
                jpt_pkg::OP_SET:
                begin
                    jerk_next = '0;
                    acc_next  = '0;
                    vel_next  = '0;
                    pos_next  = posn2;
                    idle_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            offset_reg <= '0;
            tick_reg   <= '0;
            iend_reg   <= '1;
            sp_reg     <= '0;
            first_reg  <= 1'b1;
            idle_reg   <= 1'b1;
            pos_reg    <= '0;
            vel_reg    <= '0;
            acc_reg    <= '0;
            jerk_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_reg <= cfg_wdata;
            end
            offset_reg <= offset_next;
            tick_reg   <= tick_next;
            iend_reg   <= iend_next;
            sp_reg     <= sp_next;
            first_reg  <= first_next;
            idle_reg   <= idle_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            acc_reg    <= acc_next;
            jerk_reg   <= jerk_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_first_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> (sp_reg == '0))
        else $error("first-load flag set with nonzero segment pointer");

    a_iend_floor: assert property (@(posedge clk) disable iff (!rst_n)
        iend_reg[jpt_pkg::IEND_W-1] |-> (&iend_reg))
        else $error("interval end below minus one");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("accepted start reports done");

    a_proc_out: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> m_tvalid)
        else $error("processed item produced no result");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int IN_W         = ((30 + 5 * 48 + 7) / 8) * 8;
    localparam int OUT_W        = ((4 * 48 + 7) / 8) * 8;
    localparam int DIR_ROWS     = 25;
    localparam int NO_CFG       = -1;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int STUCK_LIMIT  = 2000;

    typedef logic signed [47:0] val_t;
    typedef logic [jpt_pkg::OP_W-1:0]    op_t;
    typedef logic [jpt_pkg::INDEX_W-1:0] idx_t;
    typedef logic [jpt_pkg::TICKS_W-1:0] ticks_t;

    localparam val_t VMAX = 48'sh7FFF_FFFF_FFFF;
    localparam val_t VMIN = 48'sh8000_0000_0000;
    localparam val_t ONE  = 48'sh0001_0000_0000;

    localparam longint VMAX_L   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VMIN_L   = -VMAX_L - 1;
    localparam longint TICK_MAX = 64'sh0000_0000_FFFF_FFFF;

    typedef struct packed {
        op_t    op;
        idx_t   idx;
        ticks_t ticks;
        val_t   jerk;
        val_t   acc;
        val_t   vel;
        val_t   pos;
        val_t   position;
    } seg_item_t;

    typedef struct packed {
        val_t pos;
        val_t vel;
        val_t acc;
        val_t jerk;
        logic done;
        logic started;
    } motion_t;

    typedef struct packed {
        int      cfg;
        op_t     op;
        idx_t    idx;
        ticks_t  ticks;
        val_t    jerk;
        val_t    acc;
        val_t    vel;
        val_t    pos;
        val_t    position;
        logic    typed;
        motion_t known;
    } dir_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [jpt_pkg::CFG_W-1:0]    cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [IN_W-1:0]              s_tdata;
    logic [jpt_pkg::OP_W-1:0]     s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [OUT_W-1:0]             m_tdata;
    logic [1:0]                   m_tuser;

    // profile state mirrored for prediction
    longint dur_mem [64];
    longint jerk_mem [64];
    longint acc_mem [64];
    longint vel_mem [64];
    longint pos_mem [64];
    bit     written [64];
    longint move_offset = 0;
    longint tick_cnt    = 0;
    longint iv_end      = -1;
    int     seg_ptr     = 0;
    bit     first_load  = 1'b1;
    bit     halted      = 1'b1;
    longint cur_pos     = 0;
    longint cur_vel     = 0;
    longint cur_acc     = 0;
    longint cur_jerk    = 0;
    int     seg_limit   = 0;

    motion_t expected_q [$];

    bit gaps_on  = 1'b1;
    int hold_asks    = 0;
    int mismatches   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_started    = 0;
    int n_loads      = 0;
    int n_cfg        = 0;
    int stuck_cycles = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0,
          1'b1, '{'0, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, 48'sd5,
          1'b1, '{'0, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_SET, 6'd0, 24'd0, '0, '0, '0, '0, VMAX,
          1'b1, '{VMAX, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_SET, 6'd0, 24'd0, '0, '0, '0, '0, VMIN,
          1'b1, '{VMIN, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_WRITE, 6'd0, 24'd3, ONE, '0, -48'sd5, 48'sd1000, '0,
          1'b1, '{VMIN, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_WRITE, 6'd1, 24'd0, VMAX, VMAX, VMAX, VMAX, '0,
          1'b1, '{VMIN, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_WRITE, 6'd2, 24'd1, VMIN, VMIN, VMIN, VMIN, '0,
          1'b1, '{VMIN, '0, '0, '0, 1'b1, 1'b0}},
        '{NO_CFG, jpt_pkg::OP_WRITE, 6'd63, 24'hFF_FFFF, -48'sd7, -48'sd3, '0, '0, '0,
          1'b1, '{VMIN, '0, '0, '0, 1'b1, 1'b0}},
        // one-segment move
        '{1, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, 48'sd100, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        // three segments, offset saturates, start rejected while running
        '{3, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, VMAX, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_WRITE, 6'd0, 24'd2, -ONE, 48'sd3, 48'sd7, -48'sd1, '0,
          1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        // table shrinks under a running move
        '{3, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, -48'sd1, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{0, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_START, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{1, jpt_pkg::OP_TICK, 6'd0, 24'd0, '0, '0, '0, '0, '0, 1'b0, '0},
        '{NO_CFG, jpt_pkg::OP_SET, 6'd0, 24'd0, '0, '0, '0, '0, 48'sh0000_1234_5678_9ABC,
          1'b0, '0}
    };

    jerk_profile_trajectory_generator #(
        .MAX_SEGMENTS(64),
        .VALUE_BITS  (48)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic longint to_long(val_t v);
        return longint'(v);
    endfunction

    function automatic longint sat_value(longint s);
        if (s > VMAX_L)
            return VMAX_L;
        if (s < VMIN_L)
            return VMIN_L;
        return s;
    endfunction

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic void restart_counters();
        tick_cnt   = 0;
        iv_end     = -1;
        seg_ptr    = 0;
        first_load = 1'b1;
    endfunction

    function automatic void enter_segment(int p, int cnt);
        longint e;
        e = iv_end + dur_mem[p];
        iv_end   = (e > TICK_MAX) ? TICK_MAX : e;
        cur_jerk = jerk_mem[p];
        cur_acc  = acc_mem[p];
        cur_vel  = vel_mem[p];
        cur_pos  = sat_value(pos_mem[p] + move_offset);
        if (p + 1 >= cnt)
            halted = 1'b1;
        n_loads++;
    endfunction

    function automatic motion_t advance_profile(seg_item_t it);
        motion_t r;
        int      cnt;
        longint  j;
        r   = '0;
        cnt = (seg_limit > 64) ? 64 : seg_limit;
        case (it.op)
            jpt_pkg::OP_TICK:
            begin
                if (!halted && cnt > 0 && seg_ptr < cnt)
                begin
                    if (tick_cnt <= iv_end)
                    begin
                        j        = jerk_mem[seg_ptr];
                        cur_pos  = sat_value(sat_value(sat_value(cur_pos + cur_vel)
                                   + floor_div(cur_acc, 2)) + floor_div(j, 6));
                        cur_vel  = sat_value(sat_value(cur_vel + cur_acc) + floor_div(j, 2));
                        cur_acc  = sat_value(cur_acc + j);
                        cur_jerk = j;
                    end
                    else if (first_load)
                    begin
                        first_load = 1'b0;
                        seg_ptr    = 0;
                        enter_segment(0, cnt);
                    end
                    else if (seg_ptr + 1 >= cnt)
                    begin
                        halted = 1'b1;
                    end
                    else
                    begin
                        seg_ptr++;
                        enter_segment(seg_ptr, cnt);
                    end
                end
                else
                begin
                    restart_counters();
                end
                if (tick_cnt < TICK_MAX)
                    tick_cnt++;
            end
            jpt_pkg::OP_WRITE:
            begin
                dur_mem[it.idx]  = longint'(it.ticks);
                jerk_mem[it.idx] = to_long(it.jerk);
                acc_mem[it.idx]  = to_long(it.acc);
                vel_mem[it.idx]  = to_long(it.vel);
                pos_mem[it.idx]  = to_long(it.pos);
                written[it.idx]  = 1'b1;
            end
            jpt_pkg::OP_START:
            begin
                if (halted && cnt > 0)
                begin
                    move_offset = to_long(it.position);
                    restart_counters();
                    halted    = 1'b0;
                    r.started = 1'b1;
                    n_started++;
                end
            end
            jpt_pkg::OP_SET:
            begin
                cur_jerk = 0;
                cur_acc  = 0;
                cur_vel  = 0;
                cur_pos  = to_long(it.position);
                halted   = 1'b1;
            end
        endcase
        r.pos  = cur_pos[47:0];
        r.vel  = cur_vel[47:0];
        r.acc  = cur_acc[47:0];
        r.jerk = cur_jerk[47:0];
        r.done = halted;
        return r;
    endfunction

    function automatic int written_prefix();
        int k;
        k = 0;
        while (k < 64 && written[k])
            k++;
        return k;
    endfunction

    function automatic val_t random_value();
        longint s;
        case ($urandom_range(0, 9))
            0: return VMAX;
            1: return VMIN;
            2, 3: return val_t'({$urandom, $urandom});
            default:
            begin
                s = (longint'($urandom_range(0, 31)) <<< 32) + longint'($urandom)
                    - (longint'(1) <<< 36);
                return s[47:0];
            end
        endcase
    endfunction

    function automatic seg_item_t make_item(op_t op, int idx);
        seg_item_t it;
        it.op       = op;
        it.idx      = idx[jpt_pkg::INDEX_W-1:0];
        it.ticks    = ($urandom_range(0, 19) == 0) ? ticks_t'($urandom_range(0, 24'hFF_FFFF))
                                                   : ticks_t'($urandom_range(0, 4));
        it.jerk     = random_value();
        it.acc      = random_value();
        it.vel      = random_value();
        it.pos      = random_value();
        it.position = random_value();
        return it;
    endfunction

    task automatic send(seg_item_t it, bit typed, motion_t known);
        motion_t e;
        while (gaps_on && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.position, it.pos, it.vel, it.acc, it.jerk, it.ticks, it.idx};
        s_tuser  <= it.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e = advance_profile(it);
        expected_q.insert(expected_q.size(), typed ? known : e);
        n_sent++;
    endtask

    task automatic set_segment_count(int value);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[jpt_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        seg_limit = value;
        n_cfg++;
    endtask

    task automatic run_move(int n, int force_cnt);
        int cnt;
        int shrink_at;
        int prefix_len;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send(make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 63)), 1'b0, '0);
            send(make_item(jpt_pkg::OP_WRITE, i), 1'b0, '0);
        end
        prefix_len = written_prefix();
        cnt = n;
        case ($urandom_range(0, 7))
            0: cnt = 0;
            1: cnt = $urandom_range(1, prefix_len);
            2: if (prefix_len == 64) cnt = $urandom_range(64, 127);
            default: ;
        endcase
        if (force_cnt >= 0)
            cnt = force_cnt;
        set_segment_count(cnt);
        if ($urandom_range(0, 9) != 0)
            send(make_item(jpt_pkg::OP_START, $urandom_range(0, 63)), 1'b0, '0);
        shrink_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : -1;
        for (int t = 0; t < ((n > 8) ? 320 : 60) && !halted; t++)
        begin
            if (t == shrink_at)
                set_segment_count($urandom_range(0, cnt));
            if ($urandom_range(0, 11) == 0)
                send(make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 63)), 1'b0, '0);
            else
                send(make_item(jpt_pkg::OP_TICK, $urandom_range(0, 63)), 1'b0, '0);
        end
        if (!halted)
            send(make_item(jpt_pkg::OP_SET, $urandom_range(0, 63)), 1'b0, '0);
        send(make_item(jpt_pkg::OP_TICK, $urandom_range(0, 63)), 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h", n_checked, name, want, got);
        end
    endtask

    task automatic check_motion();
        motion_t want;
        motion_t got;
        got.pos     = m_tdata[47:0];
        got.vel     = m_tdata[95:48];
        got.acc     = m_tdata[143:96];
        got.jerk    = m_tdata[191:144];
        got.done    = m_tuser[0];
        got.started = m_tuser[1];
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing expected", n_checked);
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("pos", want.pos, got.pos);
            check_field("vel", want.vel, got.vel);
            check_field("acc", want.acc, got.acc);
            check_field("jerk", want.jerk, got.jerk);
            check_field("done", {47'd0, want.done}, {47'd0, got.done});
            check_field("accepted", {47'd0, want.started}, {47'd0, got.started});
        end
        n_checked++;
    endtask

    // output side: random backpressure plus a long hold on each request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_motion();
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !gaps_on || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("no transfer for %0d cycles", STUCK_LIMIT);
            $display("FAIL jerk_profile_trajectory_generator");
            $finish;
        end
    end

    initial
    begin
        seg_item_t it;
        int        k;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = jpt_pkg::OP_TICK;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].cfg != NO_CFG)
                set_segment_count(dir_rows[i].cfg);
            it.op       = dir_rows[i].op;
            it.idx      = dir_rows[i].idx;
            it.ticks    = dir_rows[i].ticks;
            it.jerk     = dir_rows[i].jerk;
            it.acc      = dir_rows[i].acc;
            it.vel      = dir_rows[i].vel;
            it.pos      = dir_rows[i].pos;
            it.position = dir_rows[i].position;
            send(it, dir_rows[i].typed, dir_rows[i].known);
        end

        // full 64-entry table, count beyond the table size
        run_move(64, 127);
        k = 0;
        while (n_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            gaps_on = !(k >= 4 && k < 12);
            if (k == 2 || k == 7)
                hold_asks++;
            run_move((k == 2 || k == 7) ? 6 : $urandom_range(1, 6), NO_CFG);
            k++;
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input transfers, %0d results checked, %0d segment-count writes",
                 n_sent, n_checked, n_cfg);
        $display("%0d moves started, %0d segment loads, %0d mismatches",
                 n_started, n_loads, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS jerk_profile_trajectory_generator");
        else
            $display("FAIL jerk_profile_trajectory_generator");
        $finish;
    end

endmodule
